[rtl/core/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and bit functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

  // Index 0 is hash word H0 (working variable a).
  typedef logic [0:7][31:0] hash_t;

  localparam hash_t INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  // Message buffer control
  typedef struct packed {
    logic       load;   // shift one byte in
    logic [7:0] data;
    logic       sched;  // shift one schedule word in
  } sha_buf_ctrl_t;

  // Round unit control
  typedef struct packed {
    logic       init;   // hash words back to initial values
    logic       start;  // working variables <- hash words
    logic       round;  // one compression round
    logic       update; // hash words += working variables
    logic [5:0] idx;    // round number
  } sha_rnd_ctrl_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

[rtl/core/sha_stream_if.sv]
// ----------------------------------------------------------------------------
// sha_stream_if
// Valid/ready channels of the hasher: message input and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha_msg_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface sha_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, digest_word, word_index, last, input ready);
  modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface

`default_nettype wire

[rtl/core/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256: one message byte per transaction, digest on finish.
// ----------------------------------------------------------------------------
// Data byte: taken while idle; a block's 64th byte runs 64 rounds and the hash
//   update on the shared round unit before ready returns. Finish: pad bytes
//   fill the block, then its rounds and update; a second padded block follows
//   if the length does not fit. Then 8 digest words, one a cycle while ready.
// Synchronous active-high reset: initial hash, empty buffer, zero bit count.
`default_nettype none

module sha256_stream_hasher
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sha_msg_if.sink   msg,
  sha_dig_if.source digest
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PAD    = 3'd1;
  localparam logic [2:0] S_ROUND  = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]  state;
  logic [5:0]  fill;
  logic [5:0]  rnd;
  logic [63:0] bit_len;
  logic        finishing;
  logic        final_blk;
  logic        pad_first;
  logic [2:0]  out_idx;

  logic          msg_acc;
  logic          dig_acc;
  logic [7:0]    pad_byte;
  sha_buf_ctrl_t buf_ctrl;
  sha_rnd_ctrl_t rnd_ctrl;
  logic [31:0]   w_top;
  hash_t         hash;

  assign msg.ready = (state == S_IDLE);
  assign msg_acc   = msg.valid && msg.ready;
  assign dig_acc   = digest.valid && digest.ready;

  // Length bytes occupy positions 56..63, most significant first
  always_comb begin
    if (pad_first) begin
      pad_byte = PAD_MARK;
    end else if (final_blk && fill >= LEN_POS) begin
      pad_byte = bit_len[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = '0;
    end
  end

  always_comb begin
    buf_ctrl.load  = (msg_acc && !msg.kind) || (state == S_PAD);
    buf_ctrl.data  = (state == S_PAD) ? pad_byte : msg.data_byte;
    buf_ctrl.sched = (state == S_ROUND);

    rnd_ctrl.init   = dig_acc && digest.last;
    rnd_ctrl.start  = buf_ctrl.load && (fill == 6'd63);
    rnd_ctrl.round  = (state == S_ROUND);
    rnd_ctrl.update = (state == S_UPDATE);
    rnd_ctrl.idx    = rnd;
  end

  assign digest.valid       = (state == S_OUT);
  assign digest.digest_word = hash[out_idx];
  assign digest.word_index  = out_idx;
  assign digest.last        = (out_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rnd       <= '0;
      bit_len   <= '0;
      finishing <= 1'b0;
      final_blk <= 1'b0;
      pad_first <= 1'b0;
      out_idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (msg_acc) begin
            if (!msg.kind) begin
              fill    <= fill + 6'd1;
              bit_len <= bit_len + 64'd8;
              if (fill == 6'd63) begin
                state <= S_ROUND;
                rnd   <= '0;
              end
            end else begin
              finishing <= 1'b1;
              pad_first <= 1'b1;
              // marker at 56 or later leaves no room for the length
              final_blk <= (fill < LEN_POS);
              state     <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          fill      <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= S_ROUND;
            rnd   <= '0;
          end
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (!finishing) begin
            state <= S_IDLE;
          end else if (final_blk) begin
            state   <= S_OUT;
            out_idx <= '0;
          end else begin
            final_blk <= 1'b1;
            state     <= S_PAD;
          end
        end
        S_OUT: begin
          if (dig_acc) begin
            out_idx <= out_idx + 3'd1;
            if (digest.last) begin
              state     <= S_IDLE;
              finishing <= 1'b0;
              bit_len   <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  sha_msg_buf u_buf (
    .clk   (clk),
    .ctrl  (buf_ctrl),
    .w_top (w_top)
  );

  sha_rnd u_rnd (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rnd_ctrl),
    .w    (w_top),
    .hash (hash)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg.ready && digest.valid))
    else $error("input taken while digest pending");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd == 6'd63) |=> (state == S_UPDATE))
    else $error("round count did not end compression");

  a_out_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (fill == '0 && finishing && final_blk))
    else $error("digest emitted with bytes pending");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (dig_acc && digest.last) |=> (bit_len == '0 && state == S_IDLE))
    else $error("no restart after last digest word");

endmodule

`default_nettype wire

[rtl/core/sha_msg_buf.sv]
// ----------------------------------------------------------------------------
// sha_msg_buf
// 64-byte block shift line; doubles as the rolling 16-word message schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_msg_buf
  import sha_pkg::*;
(
  input  logic          clk,
  input  sha_buf_ctrl_t ctrl,
  output logic [31:0]   w_top
);

  // Word i of the window sits at bits [511-32*i -: 32]; word 0 is W[t].
  logic [511:0] blk;
  logic [31:0]  w_new;

  assign w_top = blk[511:480];

  // W[t+16] from window words 0, 1, 9, 14
  assign w_new = blk[511:480] + small_sig0(blk[479:448]) + blk[223:192]
               + small_sig1(blk[63:32]);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      blk <= {blk[503:0], ctrl.data};
    end else if (ctrl.sched) begin
      blk <= {blk[479:0], w_new};
    end
  end

endmodule

`default_nettype wire

[rtl/core/sha_rnd.sv]
// ----------------------------------------------------------------------------
// sha_rnd
// Compression round unit: working variables, hash words, one round a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_rnd
  import sha_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  sha_rnd_ctrl_t ctrl,
  input  logic [31:0]   w,
  output hash_t         hash
);

  hash_t       v;
  logic [31:0] t1;
  logic [31:0] t2;

  assign t1 = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + ROUND_K[ctrl.idx] + w;
  assign t2 = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      v <= hash;
    end else if (ctrl.round) begin
      v <= {t1 + t2, v[0], v[1], v[2], v[3] + t1, v[4], v[5], v[6]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      hash <= INIT_HASH;
    end else if (ctrl.update) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + v[i];
      end
    end
  end

endmodule

`default_nettype wire
